// File: rtl/lc3_pkg.sv
package lc3_pkg;

   localparam int WORD_BITS = 16;
   localparam int CHAR_BITS = 8;
   localparam int REG_SEL_BITS = 3;
   localparam int REG_COUNT = 1 << REG_SEL_BITS;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [2:0] cc_type;
   typedef logic [CHAR_BITS-1:0] char_type;
   typedef logic [REG_SEL_BITS-1:0] reg_sel_type;

   localparam cc_type CC_N = 3'd4;
   localparam cc_type CC_Z = 3'd2;
   localparam cc_type CC_P = 3'd1;

   localparam logic [7:0] VEC_GETC = 8'h20;
   localparam logic [7:0] VEC_OUT  = 8'h21;
   localparam logic [7:0] VEC_PUTS = 8'h22;
   localparam logic [7:0] VEC_IN   = 8'h23;
   localparam logic [7:0] VEC_HALT = 8'h25;

   typedef enum logic [1:0] {
      REQ_STEP,
      REQ_MEM_WRITE,
      REQ_REG_WRITE,
      REQ_SET_PC
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_EXECUTED,
      ST_NOT_RUNNING,
      ST_WRITE_DONE,
      ST_CHAR_OUT
   } rsp_status_type;

   typedef enum logic [3:0] {
      OP_BR   = 4'd0,
      OP_ADD  = 4'd1,
      OP_LD   = 4'd2,
      OP_ST   = 4'd3,
      OP_JSR  = 4'd4,
      OP_AND  = 4'd5,
      OP_LDR  = 4'd6,
      OP_STR  = 4'd7,
      OP_RTI  = 4'd8,
      OP_NOT  = 4'd9,
      OP_LDI  = 4'd10,
      OP_STI  = 4'd11,
      OP_JMP  = 4'd12,
      OP_RES  = 4'd13,
      OP_LEA  = 4'd14,
      OP_TRAP = 4'd15
   } opcode_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LATCH,
      DP_MEM_WRITE,
      DP_REG_WRITE,
      DP_SET_PC,
      DP_CLEAR,
      DP_FETCH,
      DP_DECODE,
      DP_EXEC,
      DP_READ_MAR,
      DP_INDIRECT,
      DP_LOAD_WB,
      DP_STORE,
      DP_STR_NEXT
   } dp_op_type;

   typedef enum logic [1:0] {
      CH_ZERO,
      CH_REG,
      CH_MEM
   } char_sel_type;

   typedef struct packed {
      dp_op_type      op;
      logic           rsp_load;
      rsp_status_type rsp_status;
      char_sel_type   char_sel;
      logic           rsp_last;
   } dp_cmd_type;

   typedef struct packed {
      req_kind_type req_kind;
      logic         run;
      word_type     ir;
      logic         rd_zero;
      logic         cnt_done;
      logic         clr_last;
   } dp_stat_type;

   function automatic word_type sext5(word_type v);
      return {{11{v[4]}}, v[4:0]};
   endfunction

   function automatic word_type sext6(word_type v);
      return {{10{v[5]}}, v[5:0]};
   endfunction

   function automatic word_type sext9(word_type v);
      return {{7{v[8]}}, v[8:0]};
   endfunction

   function automatic word_type sext11(word_type v);
      return {{5{v[10]}}, v[10:0]};
   endfunction

   function automatic cc_type cc_of(word_type v);
      cc_type c;
      if (v[WORD_BITS-1]) begin
         c = CC_N;
      end else if (v == '0) begin
         c = CC_Z;
      end else begin
         c = CC_P;
      end
      return c;
   endfunction

endpackage

// File: rtl/lc3_req_if.sv
interface lc3_req_if import lc3_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   word_type   target_addr;
   word_type   write_data;
   char_type   in_char;

   modport source (output valid, output req_type, output target_addr, output write_data,
                   output in_char, input ready);
   modport sink (input valid, input req_type, input target_addr, input write_data,
                 input in_char, output ready);
endinterface

// File: rtl/lc3_rsp_if.sv
interface lc3_rsp_if import lc3_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] status;
   word_type   pc_now;
   word_type   instr_word;
   cc_type     cond_code;
   logic       is_running;
   char_type   char_out;
   logic       last;

   modport source (output valid, output status, output pc_now, output instr_word,
                   output cond_code, output is_running, output char_out, output last,
                   input ready);
   modport sink (input valid, input status, input pc_now, input instr_word,
                 input cond_code, input is_running, input char_out, input last,
                 output ready);
endinterface

// File: rtl/lc3_datapath.sv
module lc3_datapath import lc3_pkg::*; #(
   parameter int ADDR_BITS = 16,
   parameter int MAX_STRING_CHARS = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic [1:0]  req_type,
   input  word_type    target_addr,
   input  word_type    write_data,
   input  char_type    in_char,
   output logic [1:0]  status,
   output word_type    pc_now,
   output word_type    instr_word,
   output cc_type      cond_code,
   output logic        is_running,
   output char_type    char_out,
   output logic        last
);

   localparam int MEM_WORDS = 1 << ADDR_BITS;
   localparam int CNT_BITS = $clog2(MAX_STRING_CHARS + 1);

   typedef logic [ADDR_BITS-1:0] maddr_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   word_type mem [MEM_WORDS];
   word_type mem_rd_ff;
   logic mem_we, mem_re;
   maddr_type mem_wa, mem_ra;
   word_type mem_wd;

   word_type rf [REG_COUNT];
   logic [REG_COUNT-1:0] rf_valid_ff;
   logic rf_we;
   reg_sel_type rf_wa;
   word_type rf_wd;
   word_type ra_ff, rb_ff;
   reg_sel_type rd_a, rd_b;
   opcode_type dec_op;

   word_type pc_ff, pc_in, ir_ff, ir_in, mar_ff, mar_in;
   cc_type cc_ff, cc_in;
   logic run_ff, run_in;
   cnt_type cnt_ff, cnt_in;
   maddr_type clr_ff, clr_in;

   req_kind_type req_kind_ff;
   word_type addr_ff, data_ff;
   char_type char_ff;

   rsp_status_type rsp_status_ff;
   char_type rsp_char_ff, char_sel;
   logic rsp_last_ff;

   opcode_type op;
   reg_sel_type dr;
   word_type pc_off9, base_off6, alu_b, alu_r;

   assign op = opcode_type'(ir_ff[15:12]);
   assign dr = ir_ff[11:9];
   assign pc_off9 = pc_ff + sext9(ir_ff);
   assign base_off6 = ra_ff + sext6(ir_ff);
   assign alu_b = ir_ff[5] ? sext5(ir_ff) : rb_ff;
   assign alu_r = (op == OP_ADD) ? (ra_ff + alu_b) : (ra_ff & alu_b);

   // register read addresses come from the word just fetched
   assign dec_op = opcode_type'(mem_rd_ff[15:12]);
   assign rd_a = (dec_op == OP_TRAP) ? reg_sel_type'(0) : mem_rd_ff[8:6];
   assign rd_b = (dec_op == OP_ADD || dec_op == OP_AND) ? mem_rd_ff[2:0] : mem_rd_ff[11:9];

   always_comb begin
      pc_in = pc_ff;
      ir_in = ir_ff;
      mar_in = mar_ff;
      cc_in = cc_ff;
      run_in = run_ff;
      cnt_in = cnt_ff;
      clr_in = clr_ff;
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      mem_re = 1'b0;
      mem_ra = '0;
      rf_we = 1'b0;
      rf_wa = dr;
      rf_wd = '0;
      unique case (cmd.op)
         DP_NOP, DP_LATCH: begin
         end
         DP_MEM_WRITE: begin
            mem_we = 1'b1;
            mem_wa = addr_ff[ADDR_BITS-1:0];
            mem_wd = data_ff;
         end
         DP_REG_WRITE: begin
            rf_we = 1'b1;
            rf_wa = addr_ff[REG_SEL_BITS-1:0];
            rf_wd = data_ff;
         end
         DP_SET_PC: begin
            pc_in = addr_ff;
            run_in = 1'b1;
         end
         DP_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
         end
         DP_FETCH: begin
            mem_re = 1'b1;
            mem_ra = pc_ff[ADDR_BITS-1:0];
         end
         DP_DECODE: begin
            ir_in = mem_rd_ff;
            pc_in = pc_ff + 1'b1;
         end
         DP_EXEC: begin
            unique case (op)
               OP_BR: begin
                  if ((dr & cc_ff) != '0) begin
                     pc_in = pc_off9;
                  end
               end
               OP_ADD, OP_AND: begin
                  rf_we = 1'b1;
                  rf_wd = alu_r;
                  cc_in = cc_of(alu_r);
               end
               OP_NOT: begin
                  rf_we = 1'b1;
                  rf_wd = ~ra_ff;
                  cc_in = cc_of(~ra_ff);
               end
               OP_LEA: begin
                  rf_we = 1'b1;
                  rf_wd = pc_off9;
                  cc_in = cc_of(pc_off9);
               end
               OP_LD, OP_LDI, OP_ST, OP_STI: begin
                  mar_in = pc_off9;
               end
               OP_LDR, OP_STR: begin
                  mar_in = base_off6;
               end
               OP_JSR: begin
                  rf_we = 1'b1;
                  rf_wa = reg_sel_type'(7);
                  rf_wd = pc_ff;
                  pc_in = ir_ff[11] ? (pc_ff + sext11(ir_ff)) : ra_ff;
               end
               OP_JMP: begin
                  pc_in = ra_ff;
               end
               OP_TRAP: begin
                  unique case (ir_ff[7:0])
                     VEC_GETC, VEC_IN: begin
                        rf_we = 1'b1;
                        rf_wa = '0;
                        rf_wd = {{(WORD_BITS-CHAR_BITS){1'b0}}, char_ff};
                     end
                     VEC_OUT: begin
                     end
                     VEC_PUTS: begin
                        mar_in = ra_ff;
                        cnt_in = '0;
                     end
                     VEC_HALT: begin
                        cc_in = CC_P;
                        run_in = 1'b0;
                     end
                     default: begin
                        run_in = 1'b0;
                     end
                  endcase
               end
               OP_RTI, OP_RES: begin
               end
            endcase
         end
         DP_READ_MAR: begin
            mem_re = 1'b1;
            mem_ra = mar_ff[ADDR_BITS-1:0];
         end
         DP_INDIRECT: begin
            mar_in = mem_rd_ff;
         end
         DP_LOAD_WB: begin
            rf_we = 1'b1;
            rf_wd = mem_rd_ff;
            cc_in = cc_of(mem_rd_ff);
         end
         DP_STORE: begin
            mem_we = 1'b1;
            mem_wa = mar_ff[ADDR_BITS-1:0];
            mem_wd = rb_ff;
         end
         DP_STR_NEXT: begin
            mar_in = mar_ff + 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      unique case (cmd.char_sel)
         CH_ZERO: char_sel = '0;
         CH_REG:  char_sel = ra_ff[CHAR_BITS-1:0];
         CH_MEM:  char_sel = mem_rd_ff[CHAR_BITS-1:0];
         default: char_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         ir_ff <= '0;
         cc_ff <= CC_Z;
         run_ff <= 1'b1;
         rf_valid_ff <= '0;
         clr_ff <= '0;
      end else begin
         pc_ff <= pc_in;
         ir_ff <= ir_in;
         cc_ff <= cc_in;
         run_ff <= run_in;
         clr_ff <= clr_in;
         if (rf_we) begin
            rf_valid_ff[rf_wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mar_ff <= mar_in;
      cnt_ff <= cnt_in;
      if (cmd.op == DP_LATCH) begin
         req_kind_ff <= req_kind_type'(req_type);
         addr_ff <= target_addr;
         data_ff <= write_data;
         char_ff <= in_char;
      end
      if (rf_we) begin
         rf[rf_wa] <= rf_wd;
      end
      if (cmd.op == DP_DECODE) begin
         ra_ff <= rf_valid_ff[rd_a] ? rf[rd_a] : '0;
         rb_ff <= rf_valid_ff[rd_b] ? rf[rd_b] : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_char_ff <= char_sel;
         rsp_last_ff <= cmd.rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_ra];
      end
   end

   assign stat.req_kind = req_kind_ff;
   assign stat.run = run_ff;
   assign stat.ir = ir_ff;
   assign stat.rd_zero = (mem_rd_ff == '0);
   assign stat.cnt_done = (cnt_ff == cnt_type'(MAX_STRING_CHARS));
   assign stat.clr_last = &clr_ff;

   assign status = rsp_status_ff;
   assign pc_now = pc_ff;
   assign instr_word = ir_ff;
   assign cond_code = cc_ff;
   assign is_running = run_ff;
   assign char_out = rsp_char_ff;
   assign last = rsp_last_ff;

endmodule

// File: rtl/lc3_ctrl.sv
module lc3_ctrl import lc3_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_FETCH,
      S_DECODE,
      S_EXEC,
      S_READ1,
      S_INDIRECT,
      S_READ2,
      S_LOAD_WB,
      S_STORE,
      S_STR_READ,
      S_STR_CHECK,
      S_WAIT_CHAR,
      S_FINAL,
      S_WAIT_LAST
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_ready_ff, req_ready_in;
   opcode_type op;
   logic is_puts;

   assign op = opcode_type'(stat.ir[15:12]);
   assign is_puts = (op == OP_TRAP) && (stat.ir[7:0] == VEC_PUTS);

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      req_ready_in = 1'b0;
      cmd.op = DP_NOP;
      cmd.rsp_load = 1'b0;
      cmd.rsp_status = ST_EXECUTED;
      cmd.char_sel = CH_ZERO;
      cmd.rsp_last = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = DP_CLEAR;
            if (stat.clr_last) begin
               state_in = S_IDLE;
               req_ready_in = 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.op = DP_LATCH;
               state_in = S_DISPATCH;
            end else begin
               req_ready_in = 1'b1;
            end
         end
         S_DISPATCH: begin
            unique case (stat.req_kind)
               REQ_MEM_WRITE, REQ_REG_WRITE, REQ_SET_PC: begin
                  unique case (stat.req_kind)
                     REQ_MEM_WRITE: cmd.op = DP_MEM_WRITE;
                     REQ_REG_WRITE: cmd.op = DP_REG_WRITE;
                     default:       cmd.op = DP_SET_PC;
                  endcase
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_status = ST_WRITE_DONE;
                  cmd.rsp_last = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in = S_WAIT_LAST;
               end
               REQ_STEP: begin
                  if (stat.run) begin
                     cmd.op = DP_FETCH;
                     state_in = S_DECODE;
                  end else begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_status = ST_NOT_RUNNING;
                     cmd.rsp_last = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in = S_WAIT_LAST;
                  end
               end
            endcase
         end
         S_FETCH: begin
            cmd.op = DP_FETCH;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            cmd.op = DP_DECODE;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.op = DP_EXEC;
            priority if (op == OP_LD || op == OP_LDR || op == OP_LDI || op == OP_STI) begin
               state_in = S_READ1;
            end else if (op == OP_ST || op == OP_STR) begin
               state_in = S_STORE;
            end else if (op == OP_TRAP && stat.ir[7:0] == VEC_OUT) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_status = ST_CHAR_OUT;
               cmd.char_sel = CH_REG;
               rsp_valid_in = 1'b1;
               state_in = S_WAIT_CHAR;
            end else if (is_puts) begin
               state_in = S_STR_READ;
            end else begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_last = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_WAIT_LAST;
            end
         end
         S_READ1: begin
            cmd.op = DP_READ_MAR;
            priority if (op == OP_LDI || op == OP_STI) begin
               state_in = S_INDIRECT;
            end else begin
               state_in = S_LOAD_WB;
            end
         end
         S_INDIRECT: begin
            cmd.op = DP_INDIRECT;
            state_in = (op == OP_STI) ? S_STORE : S_READ2;
         end
         S_READ2: begin
            cmd.op = DP_READ_MAR;
            state_in = S_LOAD_WB;
         end
         S_LOAD_WB, S_STORE: begin
            cmd.op = (state_ff == S_STORE) ? DP_STORE : DP_LOAD_WB;
            cmd.rsp_load = 1'b1;
            cmd.rsp_last = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_WAIT_LAST;
         end
         S_STR_READ: begin
            if (stat.cnt_done) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_last = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_WAIT_LAST;
            end else begin
               cmd.op = DP_READ_MAR;
               state_in = S_STR_CHECK;
            end
         end
         S_STR_CHECK: begin
            if (stat.rd_zero) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_last = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_WAIT_LAST;
            end else begin
               cmd.op = DP_STR_NEXT;
               cmd.rsp_load = 1'b1;
               cmd.rsp_status = ST_CHAR_OUT;
               cmd.char_sel = CH_MEM;
               rsp_valid_in = 1'b1;
               state_in = S_WAIT_CHAR;
            end
         end
         S_WAIT_CHAR: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in = is_puts ? S_STR_READ : S_FINAL;
            end
         end
         S_FINAL: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_last = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_WAIT_LAST;
         end
         S_WAIT_LAST: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               req_ready_in = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/lc3_instruction_executor_unit.sv
// LC-3 executor: one request at a time on req_ch, one or more results on rsp_ch, the
// final one flagged by last. After reset the unit zeroes main memory one word per cycle
// and takes no request until that pass ends. Memory and register writes and set-pc are
// latched, then applied in the dispatch state, which registers the result. A step runs
// dispatch with fetch, decode, execute, then read and write-back for LD/LDR, store for
// ST/STR, read, indirect, read, write-back for LDI, read, indirect, store for STI: each
// memory access has its own state. OUT passes its character, then a final state, ahead
// of the final result; PUTS reads and checks each character and the terminator, waiting
// for each character to be taken. Ready returns in the cycle after the final result is taken.
module lc3_instruction_executor_unit import lc3_pkg::*; #(
   parameter int ADDR_BITS = 16,
   parameter int MAX_STRING_CHARS = 63
) (
   input logic        clock,
   input logic        reset,
   lc3_req_if.sink    req_ch,
   lc3_rsp_if.source  rsp_ch
);

   dp_cmd_type cmd;
   dp_stat_type stat;

   lc3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   lc3_datapath #(
      .ADDR_BITS        (ADDR_BITS),
      .MAX_STRING_CHARS (MAX_STRING_CHARS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_type    (req_ch.req_type),
      .target_addr (req_ch.target_addr),
      .write_data  (req_ch.write_data),
      .in_char     (req_ch.in_char),
      .status      (rsp_ch.status),
      .pc_now      (rsp_ch.pc_now),
      .instr_word  (rsp_ch.instr_word),
      .cond_code   (rsp_ch.cond_code),
      .is_running  (rsp_ch.is_running),
      .char_out    (rsp_ch.char_out),
      .last        (rsp_ch.last)
   );

endmodule

// File: rtl/lc3_checker.sv
module lc3_checker import lc3_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic       rsp_is_running,
   input logic       rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("request taken while a result is pending");

   a_halted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOT_RUNNING |-> !rsp_is_running && rsp_last)
      else $error("not-running result while running");

   a_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_CHAR_OUT |-> !rsp_last && rsp_is_running)
      else $error("character result flagged last");

endmodule

bind lc3_instruction_executor_unit lc3_checker u_lc3_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_is_running (rsp_ch.is_running),
   .rsp_last       (rsp_ch.last)
);

// File: sim/tb_lc3_instruction_executor_unit.sv
module tb_lc3_instruction_executor_unit;
   import lc3_pkg::*;

   typedef struct packed {
      rsp_status_type status;
      word_type       pc_now;
      word_type       instr_word;
      cc_type         cond_code;
      logic           is_running;
      char_type       char_out;
      logic           last;
   } lc3_result_type;

   class lc3_scoreboard;
      word_type       mem [0:65535];
      word_type       regs [0:7];
      word_type       pc;
      word_type       ir;
      cc_type         cc;
      logic           run;
      lc3_result_type pending[$];
      int             mismatches;

      function void clear();
         foreach (mem[i]) mem[i] = '0;
         foreach (regs[i]) regs[i] = '0;
         pc = '0;
         ir = '0;
         cc = CC_Z;
         run = 1'b1;
         mismatches = 0;
      endfunction

      function void push(rsp_status_type st, char_type ch, logic lst);
         lc3_result_type r;
         r.status = st;
         r.pc_now = pc;
         r.instr_word = ir;
         r.cond_code = cc;
         r.is_running = run;
         r.char_out = ch;
         r.last = lst;
         pending.push_back(r);
      endfunction

      function word_type sx(word_type v, int bits);
         word_type m;
         m = (16'h1 << bits) - 16'h1;
         v = v & m;
         if (v[bits-1]) v = v | ~m;
         return v;
      endfunction

      function void load_reg(logic [2:0] d, word_type v);
         regs[d] = v;
         cc = v[15] ? CC_N : (v == '0 ? CC_Z : CC_P);
      endfunction

      function void execute_instr(char_type inch);
         opcode_type op;
         logic [2:0] d, s;
         word_type   npc, b, tgt, a, w;
         ir = mem[pc];
         npc = pc + 16'd1;
         pc = npc;
         op = opcode_type'(ir[15:12]);
         d = ir[11:9];
         s = ir[8:6];
         case (op)
            OP_BR: if ((d & cc) != 0) pc = npc + sx(ir, 9);
            OP_ADD, OP_AND: begin
               b = ir[5] ? sx(ir, 5) : regs[ir[2:0]];
               load_reg(d, op == OP_ADD ? regs[s] + b : regs[s] & b);
            end
            OP_LD: load_reg(d, mem[npc + sx(ir, 9)]);
            OP_ST: mem[npc + sx(ir, 9)] = regs[d];
            OP_JSR: begin
               tgt = ir[11] ? npc + sx(ir, 11) : regs[s];
               regs[7] = npc;
               pc = tgt;
            end
            OP_LDR: load_reg(d, mem[regs[s] + sx(ir, 6)]);
            OP_STR: mem[regs[s] + sx(ir, 6)] = regs[d];
            OP_NOT: load_reg(d, ~regs[s]);
            OP_LDI: load_reg(d, mem[mem[npc + sx(ir, 9)]]);
            OP_STI: mem[mem[npc + sx(ir, 9)]] = regs[d];
            OP_JMP: pc = regs[s];
            OP_LEA: load_reg(d, npc + sx(ir, 9));
            OP_TRAP: begin
               case (ir[7:0])
                  VEC_GETC, VEC_IN: regs[0] = {8'h00, inch};
                  VEC_OUT: push(ST_CHAR_OUT, regs[0][7:0], 1'b0);
                  VEC_PUTS: begin
                     a = regs[0];
                     for (int k = 0; k < 63; k++) begin
                        w = mem[a];
                        if (w == '0) break;
                        push(ST_CHAR_OUT, w[7:0], 1'b0);
                        a = a + 16'd1;
                     end
                  end
                  VEC_HALT: begin
                     cc = CC_P;
                     run = 1'b0;
                  end
                  default: run = 1'b0;
               endcase
            end
            default: ;
         endcase
         push(ST_EXECUTED, '0, 1'b1);
      endfunction

      function void note_request(req_kind_type k, word_type addr, word_type data,
                                 char_type inch);
         case (k)
            REQ_MEM_WRITE: begin
               mem[addr] = data;
               push(ST_WRITE_DONE, '0, 1'b1);
            end
            REQ_REG_WRITE: begin
               regs[addr[2:0]] = data;
               push(ST_WRITE_DONE, '0, 1'b1);
            end
            REQ_SET_PC: begin
               pc = addr;
               run = 1'b1;
               push(ST_WRITE_DONE, '0, 1'b1);
            end
            default: begin
               if (!run) push(ST_NOT_RUNNING, '0, 1'b1);
               else execute_instr(inch);
            end
         endcase
      endfunction

      function void check_result(lc3_result_type got);
         lc3_result_type exp_r;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         exp_r = pending.pop_front();
         if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("expected %p got %p", exp_r, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   lc3_req_if req_ch();
   lc3_rsp_if rsp_ch();
   lc3_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   longint cycle_count = 0;

   lc3_instruction_executor_unit dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   always #1 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.req_type = '0;
      req_ch.target_addr = '0;
      req_ch.write_data = '0;
      req_ch.in_char = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: random stalls, long hold-off while hold_cycles runs down
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result({rsp_status_type'(rsp_ch.status), rsp_ch.pc_now, rsp_ch.instr_word,
                          rsp_ch.cond_code, rsp_ch.is_running, rsp_ch.char_out,
                          rsp_ch.last});
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // valid stays up after a transfer only when the next send follows at once
   task automatic send(req_kind_type k, word_type addr, word_type data, char_type inch);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= k;
      req_ch.target_addr <= addr;
      req_ch.write_data <= data;
      req_ch.in_char <= inch;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(k, addr, data, inch);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic run_program(int len);
      word_type base, w;
      int pick;
      base = 16'(($urandom_range(7) << 13) | $urandom_range(200));
      for (int i = 0; i < len; i++) begin
         w = 16'($urandom);
         pick = $urandom_range(99);
         // keep traps mostly at known vectors, sometimes garbage
         if (w[15:12] == OP_TRAP && pick < 85)
            case ($urandom_range(4))
               0: w[7:0] = VEC_GETC;
               1: w[7:0] = VEC_OUT;
               2: w[7:0] = VEC_PUTS;
               3: w[7:0] = VEC_IN;
               default: w[7:0] = VEC_HALT;
            endcase
         send(REQ_MEM_WRITE, base + 16'(i), w, '0);
      end
      for (int i = 0; i < 4; i++)
         send(REQ_MEM_WRITE, 16'(base + 16'd300 + 16'(i)), 16'($urandom_range(i == 3 ? 0 : 255)),
              '0);
      send(REQ_REG_WRITE, 16'($urandom_range(65535)), base + 16'd300, '0);
      send(REQ_SET_PC, base, 16'($urandom), '0);
      for (int i = 0; i < len; i++)
         send(REQ_STEP, 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   initial begin
      sb = new();
      sb.clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: ADD, AND, NOT, BR, LDI, JSRR, traps, edge fields
      send(REQ_REG_WRITE, 16'hFFF8, 16'h0040, '0);
      send(REQ_REG_WRITE, 16'h0007, 16'hFFFF, '0);
      send(REQ_MEM_WRITE, 16'h0040, 16'h0041, '0);
      send(REQ_MEM_WRITE, 16'h0041, 16'h8142, '0);
      send(REQ_MEM_WRITE, 16'hFFFF, 16'hFFFF, '0);
      send(REQ_MEM_WRITE, 16'h0000, 16'h1E3F, '0); // ADD imm -1
      send(REQ_MEM_WRITE, 16'h0001, 16'h5A07, '0); // AND reg
      send(REQ_MEM_WRITE, 16'h0002, 16'h993F, '0); // NOT
      send(REQ_MEM_WRITE, 16'h0003, 16'h0000, '0); // BR never
      send(REQ_MEM_WRITE, 16'h0004, 16'hA1FF, '0); // LDI
      send(REQ_MEM_WRITE, 16'h0005, 16'h4000 | 16'h01C0, '0); // JSRR R7
      send(REQ_REG_WRITE, 16'h0000, 16'h0040, '0);
      send(REQ_SET_PC, 16'h0000, '0, '0);
      for (int i = 0; i < 6; i++) send(REQ_STEP, '0, '0, 8'hFF);
      send(REQ_MEM_WRITE, 16'h0100, 16'hF022, '0);
      send(REQ_MEM_WRITE, 16'h0101, 16'hF021, '0);
      send(REQ_MEM_WRITE, 16'h0102, 16'hF020, '0);
      send(REQ_MEM_WRITE, 16'h0103, 16'hF0FF, '0);
      send(REQ_SET_PC, 16'h0100, '0, '0);
      for (int i = 0; i < 5; i++) send(REQ_STEP, '0, '0, 8'hA5);
      drain();
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 7 : (ph == 1 ? 63 : 0);
         recv_idle_pct = (ph == 0) ? 63 : (ph == 1 ? 7 : 0);
         if (ph == 2) hold_cycles = 400;
         for (int p = 0; p < 6; p++) run_program(8);
         for (int i = 0; i < 8; i++)
            send(req_kind_type'($urandom_range(3)), 16'($urandom), 16'($urandom),
                 8'($urandom));
         drain();
      end
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
